### rtl/rpt_pkg.sv
`timescale 1ns / 1ps

package rpt_pkg;

    localparam int SIDE_W        = 8;
    localparam int MIN_SIDES     = 3;
    localparam int SIDES_RESET   = 5;

    // Angles are fractions of a turn with this many fractional bits.
    localparam int ANGLE_BITS    = 32;

    // Vertex and half angle division: one quotient bit per step.
    localparam int DIV_STEPS     = 4;
    localparam int DIV_STAGES    = ANGLE_BITS / DIV_STEPS;
    localparam int REM_W         = SIDE_W + 1;

    // CORDIC datapath: 30 fractional bits plus headroom for gain overshoot.
    localparam int CF_BITS       = 30;
    localparam int CORDIC_W      = CF_BITS + 4;
    localparam int CS_W          = CF_BITS + 2;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] CF_ONE    = 34'sd1 <<< CF_BITS;
    localparam logic signed [CORDIC_W-1:0] QUARTER   = 34'sd1 <<< (ANGLE_BITS - 2);
    localparam logic signed [CORDIC_W-1:0] HALF_TURN = 34'sd1 <<< (ANGLE_BITS - 1);

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
        logic signed [CORDIC_W-1:0] a;
        case (i)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            24: a = 34'sd41;
            25: a = 34'sd20;
            26: a = 34'sd10;
            27: a = 34'sd5;
            28: a = 34'sd3;
            29: a = 34'sd1;
            30: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [CS_W-1:0] sat_cf(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        if (v > CF_ONE) begin
            r = CF_ONE;
        end else if (v < -CF_ONE) begin
            r = -CF_ONE;
        end else begin
            r = v;
        end
        return r[CS_W-1:0];
    endfunction

endpackage

### rtl/rpt_div.sv
`timescale 1ns / 1ps

// Pipelined restoring division giving round((2k+1)/(2n)) and round(1/(2n)) in turns.
module rpt_div #(
    parameter int SB_W = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [rpt_pkg::SIDE_W-1:0]          side,
    input  logic [rpt_pkg::SIDE_W-1:0]          vidx,
    input  logic [SB_W-1:0]                     in_sb,
    output logic                                out_valid,
    output logic [rpt_pkg::ANGLE_BITS-1:0]      vert,
    output logic [rpt_pkg::ANGLE_BITS-1:0]      half,
    output logic [SB_W-1:0]                     out_sb
);

    localparam int DS = rpt_pkg::DIV_STAGES;
    localparam int SPS = rpt_pkg::DIV_STEPS;
    localparam int AB = rpt_pkg::ANGLE_BITS;
    localparam int RW = rpt_pkg::REM_W;
    localparam int NW = rpt_pkg::SIDE_W;

    logic [RW-1:0] rv_src [DS];
    logic [RW-1:0] rh_src [DS];
    logic [RW-1:0] d_src  [DS];
    logic [AB-1:0] qv_src [DS];
    logic [AB-1:0] qh_src [DS];
    logic [NW-1:0] n_src  [DS];
    logic [SB_W-1:0] sb_src [DS];
    logic          v_src  [DS];

    logic [RW-1:0] rv_reg [DS];
    logic [RW-1:0] rh_reg [DS];
    logic [RW-1:0] d_reg  [DS];
    logic [AB-1:0] qv_reg [DS];
    logic [AB-1:0] qh_reg [DS];
    logic [NW-1:0] n_reg  [DS];
    logic [SB_W-1:0] sb_reg [DS];
    logic          v_reg  [DS];

    logic [RW-1:0] rv_next [DS];
    logic [RW-1:0] rh_next [DS];
    logic [AB-1:0] qv_next [DS];
    logic [AB-1:0] qh_next [DS];

    // The numerators are (2k+1)*2^32 + n and 2^32 + n: the high part seeds the
    // remainder and the 32-bit low part n is shifted in bit by bit.
    assign rv_src[0] = {vidx, 1'b1};
    assign rh_src[0] = RW'(1);
    assign d_src[0]  = {side, 1'b0};
    assign qv_src[0] = '0;
    assign qh_src[0] = '0;
    assign n_src[0]  = side;
    assign sb_src[0] = in_sb;
    assign v_src[0]  = in_valid;

    genvar s;
    generate
        for (s = 1; s < DS; s++) begin : g_link
            assign rv_src[s] = rv_reg[s-1];
            assign rh_src[s] = rh_reg[s-1];
            assign d_src[s]  = d_reg[s-1];
            assign qv_src[s] = qv_reg[s-1];
            assign qh_src[s] = qh_reg[s-1];
            assign n_src[s]  = n_reg[s-1];
            assign sb_src[s] = sb_reg[s-1];
            assign v_src[s]  = v_reg[s-1];
        end

        for (s = 0; s < DS; s++) begin : g_stage
            always_comb begin
                logic [RW-1:0] rv;
                logic [RW-1:0] rh;
                logic [AB-1:0] qv;
                logic [AB-1:0] qh;
                logic [AB-1:0] nx;
                logic [RW:0]   tv;
                logic [RW:0]   th;
                logic          b;
                rv = rv_src[s];
                rh = rh_src[s];
                qv = qv_src[s];
                qh = qh_src[s];
                nx = AB'(n_src[s]);
                for (int t = 0; t < SPS; t++) begin
                    b  = nx[AB-1-(s*SPS+t)];
                    tv = {rv, b};
                    th = {rh, b};
                    if (tv >= {1'b0, d_src[s]}) begin
                        tv = tv - {1'b0, d_src[s]};
                        qv = {qv[AB-2:0], 1'b1};
                    end else begin
                        qv = {qv[AB-2:0], 1'b0};
                    end
                    if (th >= {1'b0, d_src[s]}) begin
                        th = th - {1'b0, d_src[s]};
                        qh = {qh[AB-2:0], 1'b1};
                    end else begin
                        qh = {qh[AB-2:0], 1'b0};
                    end
                    rv = tv[RW-1:0];
                    rh = th[RW-1:0];
                end
                rv_next[s] = rv;
                rh_next[s] = rh;
                qv_next[s] = qv;
                qh_next[s] = qh;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s] <= v_src[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rv_reg[s] <= rv_next[s];
                    rh_reg[s] <= rh_next[s];
                    qv_reg[s] <= qv_next[s];
                    qh_reg[s] <= qh_next[s];
                    d_reg[s]  <= d_src[s];
                    n_reg[s]  <= n_src[s];
                    sb_reg[s] <= sb_src[s];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DS-1];
    assign vert      = qv_reg[DS-1];
    assign half      = qh_reg[DS-1];
    assign out_sb    = sb_reg[DS-1];

endmodule

### rtl/rpt_cordic.sv
`timescale 1ns / 1ps

// Two-lane rotation-mode CORDIC, one iteration per stage.
module rpt_cordic #(
    parameter int STAGES = 16,
    parameter int SB_W   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [rpt_pkg::ANGLE_BITS-1:0]         angle [2],
    input  logic [SB_W-1:0]                        in_sb,
    output logic                                   out_valid,
    output logic signed [rpt_pkg::CS_W-1:0]        cos_val [2],
    output logic signed [rpt_pkg::CS_W-1:0]        sin_val [2],
    output logic [SB_W-1:0]                        out_sb
);

    localparam int CW = rpt_pkg::CORDIC_W;
    localparam int NS = STAGES + 1;

    logic signed [CW-1:0] x_reg [NS][2];
    logic signed [CW-1:0] y_reg [NS][2];
    logic signed [CW-1:0] z_reg [NS][2];
    logic                 neg_reg [NS][2];
    logic [SB_W-1:0]      sb_reg [NS];
    logic                 v_reg  [NS];

    logic signed [CW-1:0] z_prep_next [2];
    logic                 neg_prep_next [2];

    logic signed [rpt_pkg::CS_W-1:0] cos_reg [2];
    logic signed [rpt_pkg::CS_W-1:0] sin_reg [2];
    logic [SB_W-1:0]      sb_out_reg;
    logic                 v_out_reg;

    // Fold the angle into the right half plane; the result of a folded angle is negated later.
    always_comb begin
        logic signed [CW-1:0] z;
        for (int l = 0; l < 2; l++) begin
            z = CW'($signed(angle[l]));
            neg_prep_next[l] = 1'b0;
            if (z > rpt_pkg::QUARTER) begin
                z = z - rpt_pkg::HALF_TURN;
                neg_prep_next[l] = 1'b1;
            end else if (z < -rpt_pkg::QUARTER) begin
                z = z + rpt_pkg::HALF_TURN;
                neg_prep_next[l] = 1'b1;
            end
            z_prep_next[l] = z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                x_reg[0][l]   <= rpt_pkg::CORDIC_X0;
                y_reg[0][l]   <= '0;
                z_reg[0][l]   <= z_prep_next[l];
                neg_reg[0][l] <= neg_prep_next[l];
            end
            sb_reg[0] <= in_sb;
        end
    end

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_iter
            logic signed [CW-1:0] x_next [2];
            logic signed [CW-1:0] y_next [2];
            logic signed [CW-1:0] z_next [2];

            always_comb begin
                logic signed [CW-1:0] dx;
                logic signed [CW-1:0] dy;
                for (int l = 0; l < 2; l++) begin
                    dx = y_reg[s][l] >>> s;
                    dy = x_reg[s][l] >>> s;
                    if (z_reg[s][l] >= 0) begin
                        x_next[l] = x_reg[s][l] - dx;
                        y_next[l] = y_reg[s][l] + dy;
                        z_next[l] = z_reg[s][l] - rpt_pkg::atan_turn(s);
                    end else begin
                        x_next[l] = x_reg[s][l] + dx;
                        y_next[l] = y_reg[s][l] - dy;
                        z_next[l] = z_reg[s][l] + rpt_pkg::atan_turn(s);
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s+1] <= v_reg[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        x_reg[s+1][l]   <= x_next[l];
                        y_reg[s+1][l]   <= y_next[l];
                        z_reg[s+1][l]   <= z_next[l];
                        neg_reg[s+1][l] <= neg_reg[s][l];
                    end
                    sb_reg[s+1] <= sb_reg[s];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out_reg <= 1'b0;
        end
        else if (en)
        begin
            v_out_reg <= v_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (neg_reg[STAGES][l])
                begin
                    cos_reg[l] <= rpt_pkg::sat_cf(-x_reg[STAGES][l]);
                    sin_reg[l] <= rpt_pkg::sat_cf(-y_reg[STAGES][l]);
                end
                else
                begin
                    cos_reg[l] <= rpt_pkg::sat_cf(x_reg[STAGES][l]);
                    sin_reg[l] <= rpt_pkg::sat_cf(y_reg[STAGES][l]);
                end
            end
            sb_out_reg <= sb_reg[STAGES];
        end
    end

    assign out_valid = v_out_reg;
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;
    assign out_sb    = sb_out_reg;

endmodule

### rtl/rpt_skid.sv
`timescale 1ns / 1ps

// Output register with one skid entry; upstream ready comes from a flop.
module rpt_skid #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  logic [W-1:0] up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output logic [W-1:0] dn_data
);

    logic         out_valid_reg;
    logic [W-1:0] out_data_reg;
    logic         skid_valid_reg;
    logic [W-1:0] skid_data_reg;
    logic         push;
    logic         drain;

    assign up_ready = !skid_valid_reg;
    assign push     = up_valid && up_ready;
    assign drain    = dn_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : up_data;
        end
        else if (push)
        begin
            skid_data_reg <= up_data;
        end
    end

    assign dn_valid = out_valid_reg;
    assign dn_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

endmodule

### rtl/regular_polygon_tracer_top.sv
`timescale 1ns / 1ps

// Regular polygon tracer: each phase beat (a fraction of one turn) gives one beat
// with the point at that phase on the outline of a regular polygon of unit
// circumradius, in signed Q1.OUT_FRAC_BITS. The side count comes from the
// configuration channel (reset 5, values below 3 act as 3) and may only be
// written while no beat is in flight. The pipeline takes one beat per cycle
// while it is not stalled; a beat passes through the side-count multiply,
// eight divider stages, the CORDIC iterations with their fold and saturate
// stages, four multiply and rounding stages and the output register. A stalled
// output stops the pipeline only once its one-entry skid buffer is full.
module regular_polygon_tracer_top #(
    parameter int PHASE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpt_pkg::SIDE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PHASE_BITS-1:0]         phase,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_FRAC_BITS+1:0] point_x,
    output logic signed [OUT_FRAC_BITS+1:0] point_y
);

    localparam int NW  = rpt_pkg::SIDE_W;
    localparam int AB  = rpt_pkg::ANGLE_BITS;
    localparam int CSW = rpt_pkg::CS_W;
    localparam int OW  = OUT_FRAC_BITS + 2;
    localparam int MW  = PHASE_BITS + 1;
    localparam int PW  = CSW + MW;
    localparam int SH  = 2 * rpt_pkg::CF_BITS - OUT_FRAC_BITS;
    localparam int RW  = 64 - SH;
    localparam logic signed [63:0]   ROUND_HALF = 64'sd1 <<< (SH - 1);
    localparam logic signed [RW-1:0] OUT_LIM    = {{(RW-1){1'b0}}, 1'b1} << OUT_FRAC_BITS;

    logic en;

    // Configuration.
    logic [NW-1:0] side_count_reg;
    logic [NW-1:0] n_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= NW'(rpt_pkg::SIDES_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            side_count_reg <= cfg_data;
        end
    end

    assign n_eff = (side_count_reg < NW'(rpt_pkg::MIN_SIDES)) ?
                   NW'(rpt_pkg::MIN_SIDES) : side_count_reg;

    // Front stage: scale the phase by the side count.
    logic [NW+PHASE_BITS-1:0] prod;
    logic                     v_front_reg;
    logic [NW-1:0]            n_front_reg;
    logic [NW-1:0]            k_front_reg;
    logic [PHASE_BITS-1:0]    f_front_reg;

    assign prod = (NW+PHASE_BITS)'(n_eff) * (NW+PHASE_BITS)'(phase);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_front_reg <= 1'b0;
        end
        else if (en)
        begin
            v_front_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_front_reg <= n_eff;
            k_front_reg <= prod[NW+PHASE_BITS-1:PHASE_BITS];
            f_front_reg <= prod[PHASE_BITS-1:0];
        end
    end

    // Vertex and half angles.
    logic                  v_div;
    logic [AB-1:0]         vert;
    logic [AB-1:0]         half;
    logic [PHASE_BITS-1:0] f_div;

    rpt_div #(
        .SB_W (PHASE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_front_reg),
        .side      (n_front_reg),
        .vidx      (k_front_reg),
        .in_sb     (f_front_reg),
        .out_valid (v_div),
        .vert      (vert),
        .half      (half),
        .out_sb    (f_div)
    );

    // Lane 0 carries the half angle, lane 1 the vertex angle.
    logic [AB-1:0]          angles [2];
    logic                   v_cor;
    logic signed [CSW-1:0]  cos_val [2];
    logic signed [CSW-1:0]  sin_val [2];
    logic [PHASE_BITS-1:0]  f_cor;

    assign angles[0] = half;
    assign angles[1] = vert;

    rpt_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (PHASE_BITS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_div),
        .angle     (angles),
        .in_sb     (f_div),
        .out_valid (v_cor),
        .cos_val   (cos_val),
        .sin_val   (sin_val),
        .out_sb    (f_cor)
    );

    // 2f - 1 scaled by 2^PHASE_BITS: flipping the top bit of 2f subtracts one.
    logic signed [MW-1:0] m;
    assign m = $signed({~f_cor[PHASE_BITS-1], f_cor[PHASE_BITS-2:0], 1'b0});

    logic                  v_m1_reg;
    logic signed [PW-1:0]  msr_m1_reg;
    logic signed [63:0]    pcc_m1_reg;
    logic signed [63:0]    pcs_m1_reg;
    logic signed [CSW-1:0] cv_m1_reg;
    logic signed [CSW-1:0] sv_m1_reg;

    logic                  v_m2_reg;
    logic signed [63:0]    pcc_m2_reg;
    logic signed [63:0]    pcs_m2_reg;
    logic signed [63:0]    pmsv_m2_reg;
    logic signed [63:0]    pmcv_m2_reg;
    logic signed [PW-1:0]  ms_wide;
    logic signed [CSW-1:0] ms;

    logic                  v_m3_reg;
    logic signed [63:0]    x_m3_reg;
    logic signed [63:0]    y_m3_reg;

    logic                  v_m4_reg;
    logic [OW-1:0]         x_m4_reg;
    logic [OW-1:0]         y_m4_reg;

    assign ms_wide = msr_m1_reg >>> PHASE_BITS;
    assign ms      = ms_wide[CSW-1:0];

    function automatic logic [OW-1:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0]   t;
        logic signed [RW-1:0] r;
        t = v + ROUND_HALF;
        r = t[63:SH];
        if (r > OUT_LIM) begin
            r = OUT_LIM;
        end else if (r < -OUT_LIM) begin
            r = -OUT_LIM;
        end
        return r[OW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_m1_reg <= 1'b0;
            v_m2_reg <= 1'b0;
            v_m3_reg <= 1'b0;
            v_m4_reg <= 1'b0;
        end
        else if (en)
        begin
            v_m1_reg <= v_cor;
            v_m2_reg <= v_m1_reg;
            v_m3_reg <= v_m2_reg;
            v_m4_reg <= v_m3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            msr_m1_reg  <= PW'(sin_val[0]) * PW'(m);
            pcc_m1_reg  <= 64'(cos_val[0]) * 64'(cos_val[1]);
            pcs_m1_reg  <= 64'(cos_val[0]) * 64'(sin_val[1]);
            cv_m1_reg   <= cos_val[1];
            sv_m1_reg   <= sin_val[1];

            pcc_m2_reg  <= pcc_m1_reg;
            pcs_m2_reg  <= pcs_m1_reg;
            pmsv_m2_reg <= 64'(ms) * 64'(sv_m1_reg);
            pmcv_m2_reg <= 64'(ms) * 64'(cv_m1_reg);

            x_m3_reg    <= pcc_m2_reg - pmsv_m2_reg;
            y_m3_reg    <= pcs_m2_reg + pmcv_m2_reg;

            x_m4_reg    <= round_sat(x_m3_reg);
            y_m4_reg    <= round_sat(y_m3_reg);
        end
    end

    logic [2*OW-1:0] dn_data;

    rpt_skid #(
        .W (2 * OW)
    ) u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v_m4_reg),
        .up_ready (en),
        .up_data  ({x_m4_reg, y_m4_reg}),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_data  (dn_data)
    );

    assign in_ready = en;
    assign point_x  = $signed(dn_data[2*OW-1:OW]);
    assign point_y  = $signed(dn_data[OW-1:0]);

    // Checks.
    a_front_sides: assert property (@(posedge clk) disable iff (!rst_n)
        v_front_reg |-> (n_front_reg >= NW'(rpt_pkg::MIN_SIDES)))
        else $error("effective side count below minimum");

    a_front_index: assert property (@(posedge clk) disable iff (!rst_n)
        v_front_reg |-> (k_front_reg < n_front_reg))
        else $error("vertex index not below side count");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((point_x <= $signed(OUT_LIM[OW-1:0])) &&
                       (point_x >= -$signed(OUT_LIM[OW-1:0])) &&
                       (point_y <= $signed(OUT_LIM[OW-1:0])) &&
                       (point_y >= -$signed(OUT_LIM[OW-1:0]))))
        else $error("output point outside unit range");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("pipeline stalled with empty output");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int PB = 16;
    localparam int OFB = 14;
    localparam int NSTG = 16;
    localparam int LATENCY = NSTG + 16;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [rpt_pkg::SIDE_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [PB-1:0] phase;
    logic out_valid;
    logic out_ready;
    logic signed [OFB+1:0] point_x;
    logic signed [OFB+1:0] point_y;

    typedef struct packed {
        logic signed [OFB+1:0] x;
        logic signed [OFB+1:0] y;
    } point_t;

    point_t expected_points[$];
    int errors = 0;
    logic [rpt_pkg::SIDE_W-1:0] sides_reg;
    bit idle_free = 0;

    regular_polygon_tracer_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .phase(phase),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Rotation-mode CORDIC on a turn fraction with 32 fractional bits.
    task automatic turn_sincos(input longint unsigned ang, output longint c,
                               output longint s);
        longint z, x, y, dx, dy;
        longint atans[16];
        bit flip;
        atans = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                  83443, 41722, 20861};
        z = longint'(ang & 64'hFFFF_FFFF);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= (64'sd1 <<< 31)) z -= 64'sd1 <<< 32;
        if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31;
            flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31;
            flip = 1;
        end
        for (int i = 0; i < NSTG; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atans[i];
            end else begin
                x += dx; y -= dy; z += atans[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = clamp(x, 64'sd1 <<< 30);
        s = clamp(y, 64'sd1 <<< 30);
    endtask

    function automatic logic signed [OFB+1:0] to_q14(longint v);
        longint r;
        r = shr_floor(v + (64'sd1 <<< 45), 46);
        r = clamp(r, 64'sd1 <<< OFB);
        return r[OFB+1:0];
    endfunction

    task automatic polygon_point(input logic [PB-1:0] ph, output point_t p);
        longint unsigned n, prod, k, f, vert, half;
        longint ch, sh, cv, sv, m, ms;
        n = (sides_reg < rpt_pkg::MIN_SIDES) ? rpt_pkg::MIN_SIDES : sides_reg;
        prod = n * ph;
        k = prod >> PB;
        f = prod & 64'hFFFF;
        vert = (((2 * k + 1) << 32) + n) / (2 * n);
        half = ((64'd1 << 32) + n) / (2 * n);
        turn_sincos(half, ch, sh);
        turn_sincos(vert, cv, sv);
        m = longint'(2 * f) - (64'sd1 <<< PB);
        ms = shr_floor(sh * m, PB);
        p.x = to_q14(ch * cv - ms * sv);
        p.y = to_q14(ch * sv + ms * cv);
    endtask

    function automatic bit idle_now();
        return !idle_free && ($urandom_range(99) < 29);
    endfunction

    // The valid line stays high between beats unless the sender idles.
    task automatic send_phase(input logic [PB-1:0] ph);
        point_t p;
        while (idle_now()) begin
            in_valid <= 0;
            @(negedge clk);
        end
        polygon_point(ph, p);
        in_valid <= 1;
        phase <= ph;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_points.push_back(p);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (expected_points.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_sides(input logic [rpt_pkg::SIDE_W-1:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sides_reg = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic test_reset_sides();
        send_phase(16'h0000);
        send_phase(16'hFFFF);
        send_phase(16'h8000);
        send_phase(16'h3333);
    endtask

    task automatic test_extremes();
        logic [rpt_pkg::SIDE_W-1:0] cases[6] = '{8'd0, 8'd2, 8'd3, 8'd4, 8'd255, 8'd128};
        foreach (cases[i]) begin
            write_sides(cases[i]);
            send_phase(16'h0000);
            send_phase(16'hFFFF);
            send_phase(16'h4000);
            if (i < 2) send_phase(16'h5555);
        end
    endtask

    task automatic test_random();
        for (int blk = 0; blk < 25; blk++) begin
            if (blk % 5 == 0)
                write_sides(rpt_pkg::SIDE_W'($urandom_range(255)));
            idle_free = (blk == 10);
            for (int j = 0; j < 50; j++) send_phase(PB'($urandom));
            // Hold the next beat until every point has come back.
            if (blk == 3) drain();
        end
        idle_free = 0;
        write_sides(8'd255);
        for (int j = 0; j < 20; j++) send_phase(PB'($urandom));
        write_sides(8'd3);
        for (int j = 0; j < 20; j++) send_phase(PB'($urandom));
    endtask

    always @(posedge clk) begin
        point_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected point x=%0d y=%0d", $time, point_x, point_y);
                errors++;
            end else begin
                e = expected_points.pop_front();
                if (point_x !== e.x) begin
                    $display("%0t: point_x expected %0d actual %0d", $time, e.x, point_x);
                    errors++;
                end
                if (point_y !== e.y) begin
                    $display("%0t: point_y expected %0d actual %0d", $time, e.y, point_y);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk) begin
        out_ready <= !idle_now();
    end

    initial begin
        #2000000;
        $display("regular_polygon_tracer_top: mismatch");
        $finish;
    end

    initial begin
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        in_valid = 0;
        phase = '0;
        out_ready = 0;
        sides_reg = rpt_pkg::SIDE_W'(rpt_pkg::SIDES_RESET);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        test_reset_sides();
        test_extremes();
        test_random();
        drain();
        if (errors == 0 && expected_points.size() == 0)
            $display("regular_polygon_tracer_top: match");
        else
            $display("regular_polygon_tracer_top: mismatch");
        $finish;
    end
endmodule
